[rtl/blt_pkg.sv]
// Shared types, register indexes and reset constants for the LED timer.
package blt_pkg;

  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned DutyW     = 9;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned RampW     = 8;
  localparam int unsigned LevelW    = 16;

  localparam logic [CfgIndexW-1:0] RegMode   = 8'd0;
  localparam logic [CfgIndexW-1:0] RegDuty   = 8'd1;
  localparam logic [CfgIndexW-1:0] RegPeriod = 8'd2;
  localparam logic [CfgIndexW-1:0] RegStep   = 8'd3;

  localparam logic [DutyW-1:0]  DutyFull     = 9'd256;
  localparam logic [RampW-1:0]  RampTop      = 8'd254;
  localparam logic [TimeW-1:0]  TimeMax      = 16'hFFFF;

  localparam logic             ResetMode   = 1'b0;
  localparam logic [DutyW-1:0] ResetDuty   = 9'd224;
  localparam logic [TimeW-1:0] ResetPeriod = 16'd5000;
  localparam logic [TimeW-1:0] ResetStep   = 16'd10;
  localparam logic [TimeW-1:0] ResetOnTime = 16'd4375;
  localparam logic [TimeW-1:0] ResetOffTime = 16'd625;

  // Timing settings as seen by the state logic.
  typedef struct packed {
    logic             mode;
    logic [TimeW-1:0] step;
    logic [TimeW-1:0] on_time;
    logic [TimeW-1:0] off_time;
  } timing_t;

  // Current settings plus a restart request carrying the freshly written ones.
  typedef struct packed {
    logic    restart;
    timing_t fresh;
    timing_t cur;
  } blt_ctrl_t;

endpackage

[rtl/blt_cfg.sv]
// Configuration registers and the derived on and off times of the blink cycle.
module blt_cfg
  import blt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output blt_ctrl_t            ctrl
);

  logic             mode, mode_next;
  logic [DutyW-1:0] duty, duty_next;
  logic [TimeW-1:0] period, period_next;
  logic [TimeW-1:0] step, step_next;
  logic [TimeW-1:0] on_time, off_time;
  logic [TimeW-1:0] on_next, off_next;
  logic [DutyW-1:0] duty_sat;
  logic [24:0]      prod;
  logic             hit;

  always_comb begin
    mode_next   = mode;
    duty_next   = duty;
    period_next = period;
    step_next   = step;
    hit         = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        RegMode: begin
          mode_next = cfg_data[0];
          hit       = 1'b1;
        end
        RegDuty: begin
          duty_next = cfg_data[DutyW-1:0];
          hit       = 1'b1;
        end
        RegPeriod: begin
          period_next = cfg_data;
          hit         = 1'b1;
        end
        RegStep: begin
          step_next = cfg_data;
          hit       = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  // The product of a 16-bit period and a duty of at most 256 stays below 2^24.
  assign duty_sat = (duty_next > DutyFull) ? DutyFull : duty_next;
  assign prod     = 25'(period_next) * 25'(duty_sat);
  assign on_next  = prod[23:8];
  assign off_next = period_next - on_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= ResetMode;
      duty     <= ResetDuty;
      period   <= ResetPeriod;
      step     <= ResetStep;
      on_time  <= ResetOnTime;
      off_time <= ResetOffTime;
    end else if (hit) begin
      mode     <= mode_next;
      duty     <= duty_next;
      period   <= period_next;
      step     <= step_next;
      on_time  <= on_next;
      off_time <= off_next;
    end
  end

  assign ctrl.restart        = hit;
  assign ctrl.fresh.mode     = mode_next;
  assign ctrl.fresh.step     = step_next;
  assign ctrl.fresh.on_time  = on_next;
  assign ctrl.fresh.off_time = off_next;
  assign ctrl.cur.mode       = mode;
  assign ctrl.cur.step       = step;
  assign ctrl.cur.on_time    = on_time;
  assign ctrl.cur.off_time   = off_time;

endmodule

[rtl/blt_core.sv]
// Blink and breathing state, per-tick update and the registered result item.
module blt_core
  import blt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  blt_ctrl_t         ctrl,
  input  logic              accept,
  input  logic              tick,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              led_on,
  output logic [LevelW-1:0] pwm_level,
  output logic              pin_update
);

  logic [TimeW-1:0]  elapsed, elapsed_next;
  logic [TimeW-1:0]  interval, interval_next;
  logic              led, led_next;
  logic [RampW-1:0]  ramp, ramp_next;
  logic [LevelW-1:0] bright, bright_next;
  logic              rising, rising_next;
  logic              update;
  logic [TimeW-1:0]  elapsed_inc;
  logic [LevelW-1:0] delta;

  assign elapsed_inc = (elapsed < TimeMax) ? elapsed + 16'd1 : elapsed;
  assign delta       = LevelW'({ramp, 1'b1});

  always_comb begin
    elapsed_next  = elapsed;
    interval_next = interval;
    led_next      = led;
    ramp_next     = ramp;
    bright_next   = bright;
    rising_next   = rising;
    update        = 1'b0;
    if (ctrl.restart) begin
      elapsed_next = '0;
      if (ctrl.fresh.mode) begin
        ramp_next     = '0;
        bright_next   = '0;
        rising_next   = 1'b1;
        interval_next = ctrl.fresh.step;
      end else if (ctrl.fresh.on_time != '0) begin
        led_next      = 1'b1;
        interval_next = ctrl.fresh.on_time;
      end else begin
        led_next      = 1'b0;
        interval_next = ctrl.fresh.off_time;
      end
    end else if (accept && tick) begin
      elapsed_next = elapsed_inc;
      if (elapsed_inc >= interval) begin
        elapsed_next = '0;
        if (ctrl.cur.mode) begin
          update = 1'b1;
          if (rising) begin
            bright_next = bright + delta;
            if (ramp == RampTop) rising_next = 1'b0;
            else                 ramp_next   = ramp + 8'd1;
          end else begin
            bright_next = bright - delta;
            if (ramp == '0) rising_next = 1'b1;
            else            ramp_next   = ramp - 8'd1;
          end
        end else if (led && ctrl.cur.off_time != '0) begin
          led_next      = 1'b0;
          interval_next = ctrl.cur.off_time;
          update        = 1'b1;
        end else if (!led && ctrl.cur.on_time != '0) begin
          led_next      = 1'b1;
          interval_next = ctrl.cur.on_time;
          update        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      interval <= ResetOnTime;
      led      <= 1'b1;
      ramp     <= '0;
      bright   <= '0;
      rising   <= 1'b1;
    end else begin
      elapsed  <= elapsed_next;
      interval <= interval_next;
      led      <= led_next;
      ramp     <= ramp_next;
      bright   <= bright_next;
      rising   <= rising_next;
    end
  end

  // The result register refills in the same cycle that it is drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led_on     <= ctrl.cur.mode ? 1'b1 : led_next;
      pwm_level  <= ctrl.cur.mode ? bright_next : '0;
      pin_update <= update;
    end
  end

endmodule

[rtl/breathing_blink_led_timer_core.sv]
// Blink and breathing LED timer: one tick item in, one result item out.
// The result of an item is registered and shown in the cycle after it is accepted.
// Throughput: one item per cycle while the output is not stalled; the result register refills as it drains.
// A configuration write restarts the selected mode in the cycle it is taken.
// Reset restores blink mode with duty 224, period 5000 and step 10, LED on.
module breathing_blink_led_timer_core
  import blt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 tick,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 led_on,
  output logic [LevelW-1:0]    pwm_level,
  output logic                 pin_update,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  blt_ctrl_t ctrl;
  logic      accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  blt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl)
  );

  blt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .accept     (accept),
    .tick       (tick),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .led_on     (led_on),
    .pwm_level  (pwm_level),
    .pin_update (pin_update)
  );

endmodule

[dv/tb.sv]
// Self-checking testbench for the blink and breathing LED timer core.
module tb;
  import blt_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int ReportCap = 40;
  localparam int RandomTicks = 1300;
  localparam logic [CfgIndexW-1:0] RegPastEnd = RegStep + 1'b1;
  localparam logic [CfgIndexW-1:0] RegIndexTop = '1;

  typedef struct packed {
    logic              led_on;
    logic [LevelW-1:0] pwm;
    logic              pin_update;
  } led_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 tick = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 led_on;
  logic [LevelW-1:0]    pwm_level;
  logic                 pin_update;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  breathing_blink_led_timer_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .tick       (tick),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .led_on     (led_on),
    .pwm_level  (pwm_level),
    .pin_update (pin_update),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Timer settings and state as the predictor sees them.
  logic              mode_reg;
  logic [DutyW-1:0]  duty_reg;
  logic [TimeW-1:0]  period_reg;
  logic [TimeW-1:0]  step_reg;
  logic [TimeW-1:0]  elapsed;
  logic [TimeW-1:0]  interval;
  logic              led;
  logic [RampW-1:0]  ramp_x;
  logic [LevelW-1:0] level;
  logic              rising;

  bit          tick_queue[$];
  led_result_t expected_results[$];
  led_result_t want;
  bit          tick_taken = 1'b0;
  bit          calm = 1'b0;
  int          ticks_queued = 0;
  int          ticks_taken = 0;
  int          zero_ticks = 0;
  int          cfg_taken = 0;
  int          results_checked = 0;
  int          pin_updates = 0;
  int          errors = 0;
  int          quiet_cycles = 0;
  logic [LevelW-1:0] peak_level = '0;

  function automatic logic [TimeW-1:0] on_span();
    logic [DutyW-1:0] d;
    logic [31:0]      prod;
    d = (duty_reg > DutyFull) ? DutyFull : duty_reg;
    prod = 32'(period_reg) * 32'(d);
    return prod[23:8];
  endfunction

  function automatic logic [TimeW-1:0] off_span();
    return period_reg - on_span();
  endfunction

  function automatic void restart_mode();
    elapsed = '0;
    if (mode_reg) begin
      ramp_x = '0;
      level = '0;
      rising = 1'b1;
      interval = step_reg;
    end else if (on_span() != 0) begin
      led = 1'b1;
      interval = on_span();
    end else begin
      led = 1'b0;
      interval = off_span();
    end
  endfunction

  function automatic void reset_timer_model();
    mode_reg = ResetMode;
    duty_reg = ResetDuty;
    period_reg = ResetPeriod;
    step_reg = ResetStep;
    ramp_x = '0;
    level = '0;
    rising = 1'b1;
    led = 1'b1;
    restart_mode();
  endfunction

  function automatic void apply_reg_write(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      RegMode: mode_reg = data[0];
      RegDuty: duty_reg = data[DutyW-1:0];
      RegPeriod: period_reg = data;
      RegStep: step_reg = data;
      default: return;
    endcase
    restart_mode();
  endfunction

  function automatic led_result_t advance_timer(logic t);
    led_result_t r;
    logic [LevelW-1:0] delta;
    r.pin_update = 1'b0;
    if (t) begin
      if (elapsed != TimeMax) elapsed++;
      if (elapsed >= interval) begin
        elapsed = '0;
        if (mode_reg) begin
          delta = {7'd0, ramp_x, 1'b1};
          if (rising) begin
            level = level + delta;
            if (ramp_x == RampTop) rising = 1'b0;
            else ramp_x++;
          end else begin
            level = level - delta;
            if (ramp_x == 0) rising = 1'b1;
            else ramp_x--;
          end
          r.pin_update = 1'b1;
        end else if (led && off_span() != 0) begin
          led = 1'b0;
          interval = off_span();
          r.pin_update = 1'b1;
        end else if (!led && on_span() != 0) begin
          led = 1'b1;
          interval = on_span();
          r.pin_update = 1'b1;
        end
      end
    end
    r.led_on = mode_reg ? 1'b1 : led;
    r.pwm = mode_reg ? level : '0;
    return r;
  endfunction

  function automatic void note_mismatch(string field, int exp_val, int act_val);
    if (errors < ReportCap)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
    errors++;
  endfunction

  // Tick item driver: holds an item until it is taken, then may idle.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tick_taken) begin
      if (tick_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
        in_valid <= 1'b1;
        tick <= tick_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(0, 99) < 38);
  end

  // Monitor: predicts on every accepted item and checks every accepted result.
  always @(posedge clk) begin
    if (rst) begin
      reset_timer_model();
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_checked++;
        if (pin_update) pin_updates++;
        if (pwm_level > peak_level) peak_level = pwm_level;
        if (expected_results.size() == 0) begin
          if (errors < ReportCap)
            $display("%0t: result with no item pending, led_on %0b pwm_level %0d pin_update %0b",
                     $time, led_on, pwm_level, pin_update);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.led_on !== led_on) note_mismatch("led_on", want.led_on, led_on);
          if (want.pwm !== pwm_level) note_mismatch("pwm_level", want.pwm, pwm_level);
          if (want.pin_update !== pin_update)
            note_mismatch("pin_update", want.pin_update, pin_update);
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
        cfg_taken++;
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(advance_timer(tick));
        ticks_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_tick(bit t);
    tick_queue.push_back(t);
    ticks_queued++;
    if (!t) zero_ticks++;
  endfunction

  task automatic wait_idle();
    while (ticks_taken != ticks_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    int start;
    start = cfg_taken;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (cfg_taken == start);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int random_ticks;
    int n;
    logic [CfgDataW-1:0] v;
    random_ticks = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, including an item that carries no time.
    queue_tick(1'b0);
    queue_tick(1'b1);
    queue_tick(1'b1);
    wait_idle();
    // Two ticks on, two off.
    write_reg(RegPeriod, 16'd4);
    write_reg(RegDuty, 16'd128);
    repeat (6) queue_tick(1'b1);
    wait_idle();
    // No on phase: the LED starts off and the empty on phase is skipped.
    write_reg(RegDuty, 16'd0);
    write_reg(RegPeriod, 16'd3);
    repeat (4) queue_tick(1'b1);
    wait_idle();
    // Duty above full saturates, so the LED stays on.
    write_reg(RegDuty, 16'hFFFF);
    repeat (4) queue_tick(1'b1);
    wait_idle();
    // Zero period expires on every tick.
    write_reg(RegPeriod, 16'd0);
    write_reg(RegDuty, 16'd128);
    repeat (2) queue_tick(1'b1);
    wait_idle();
    write_reg(RegMode, 16'd1);
    write_reg(RegStep, 16'd1);
    queue_tick(1'b1);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b1);
    wait_idle();
    write_reg(RegStep, 16'd0);
    repeat (2) queue_tick(1'b1);
    wait_idle();
    // Writes past the register list must not restart the ramp.
    write_reg(RegPastEnd, 16'h5A5A);
    write_reg(RegIndexTop, 16'hFFFF);
    repeat (2) queue_tick(1'b1);
    wait_idle();

    // One full breath up to the peak and back, with no idling on either side.
    calm = 1'b1;
    write_reg(RegStep, 16'd1);
    repeat (530) queue_tick(1'b1);
    wait_idle();
    calm = 1'b0;

    while (random_ticks < RandomTicks) begin
      wait_idle();
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0, 1, 9: write_reg(RegMode, CfgDataW'($urandom_range(0, 65535)));
          2, 3: begin
            case ($urandom_range(0, 5))
              0: v = 16'd0;
              1: v = 16'd256;
              2: v = 16'd255;
              3: v = CfgDataW'($urandom_range(257, 511));
              4: v = CfgDataW'($urandom_range(1, 255));
              default: v = CfgDataW'($urandom_range(0, 65535));
            endcase
            write_reg(RegDuty, v);
          end
          4, 5: begin
            case ($urandom_range(0, 6))
              0: v = 16'd0;
              1: v = 16'd1;
              2: v = 16'd2;
              3, 4: v = CfgDataW'($urandom_range(3, 24));
              5: v = CfgDataW'($urandom_range(0, 65535));
              default: v = TimeMax;
            endcase
            write_reg(RegPeriod, v);
          end
          6, 7: begin
            case ($urandom_range(0, 5))
              0: v = 16'd0;
              1: v = 16'd1;
              2: v = 16'd2;
              3: v = 16'd3;
              4: v = CfgDataW'($urandom_range(4, 8));
              default: v = CfgDataW'($urandom_range(0, 65535));
            endcase
            write_reg(RegStep, v);
          end
          default: write_reg(CfgIndexW'($urandom_range(RegPastEnd, RegIndexTop)),
                             CfgDataW'($urandom_range(0, 65535)));
        endcase
      end
      n = $urandom_range(10, 80);
      repeat (n) queue_tick($urandom_range(0, 9) != 0);
      random_ticks += n;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("Sent %0d tick items (%0d carrying no time) over %0d register writes.",
             ticks_taken, zero_ticks, cfg_taken);
    $display("Checked %0d results, %0d of them pin updates; highest brightness seen %0d.",
             results_checked, pin_updates, peak_level);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
